// ===== hdl/wdre_pkg.sv =====
// ----------------------------------------------------------------------------
// wdre_pkg
// Shared widths, constants and types of the windowed dequeue-rate estimator.
// ----------------------------------------------------------------------------
package wdre_pkg;

   localparam int PORT_W  = 7;
   localparam int PRIO_W  = 3;
   localparam int BYTES_W = 16;
   localparam int TIME_W  = 63;
   localparam int SUM_W   = 24;
   localparam int RATE_W  = 40;
   localparam int FRAC_W  = 17;
   localparam int CNT_W   = 7;

   localparam logic [RATE_W-1:0] LINE_RATE_RESET = 40'd10000000000;
   localparam logic [SUM_W-1:0]  SUM_BIAS        = 24'd1500;
   localparam logic [FRAC_W-1:0] ONE_FIX         = 17'd65536;
   localparam logic [29:0]       NS_PER_S        = 30'd1000000000;

   localparam logic REQ_RECORD = 1'b0;
   localparam logic REQ_QUERY  = 1'b1;

   typedef struct packed {
      logic              start;
      logic [SUM_W-1:0]  sum;
      logic [TIME_W-1:0] span;
      logic [RATE_W-1:0] rate;
   } calc_req_type;

   typedef struct packed {
      logic              done;
      logic [FRAC_W-1:0] frac;
   } calc_rsp_type;

endpackage

// ===== hdl/wdre_if.sv =====
// ----------------------------------------------------------------------------
// wdre_req_if / wdre_rsp_if
// Valid/ready channels carrying estimator requests and rate responses.
// ----------------------------------------------------------------------------
interface wdre_req_if;
   import wdre_pkg::*;
   logic               valid;
   logic               ready;
   logic               req_type;
   logic [PORT_W-1:0]  port_index;
   logic [PRIO_W-1:0]  prio_index;
   logic [BYTES_W-1:0] byte_count;
   logic [TIME_W-1:0]  now_time;

   modport source (output valid, req_type, port_index, prio_index, byte_count, now_time,
                   input ready);
   modport sink   (input valid, req_type, port_index, prio_index, byte_count, now_time,
                   output ready);
endinterface

interface wdre_rsp_if;
   import wdre_pkg::*;
   logic              valid;
   logic              ready;
   logic [FRAC_W-1:0] rate_fraction;
   logic [CNT_W-1:0]  sample_count;

   modport source (output valid, rate_fraction, sample_count, input ready);
   modport sink   (input valid, rate_fraction, sample_count, output ready);
endinterface

// ===== hdl/wdre_ram.sv =====
// ----------------------------------------------------------------------------
// wdre_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module wdre_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                  clock,
   input  logic                                  wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                      wr_data,
   input  logic                                  rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                      rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== hdl/wdre_calc.sv =====
// ----------------------------------------------------------------------------
// wdre_calc
// Rate fraction unit: 8e9*sum over span*rate, four partial products for the
// denominator, then a 16-step restoring divide with saturation to 1.0.
// ----------------------------------------------------------------------------
module wdre_calc (
   input  logic                  clock,
   input  logic                  reset,
   input  wdre_pkg::calc_req_type calc_req,
   output wdre_pkg::calc_rsp_type calc_rsp
);
   import wdre_pkg::*;

   localparam int DEN_W = TIME_W + RATE_W;
   localparam int NUM_W = DEN_W + 1;

   localparam logic [1:0] C_IDLE = 2'd0;
   localparam logic [1:0] C_MUL  = 2'd1;
   localparam logic [1:0] C_CMP  = 2'd2;
   localparam logic [1:0] C_DIV  = 2'd3;

   logic [1:0]        state_ff, state_in;
   logic [3:0]        step_ff, step_in;
   logic [NUM_W-1:0]  num_ff, num_in;
   logic [DEN_W-1:0]  den_ff, den_in;
   logic [TIME_W-1:0] span_ff, span_in;
   logic [RATE_W-1:0] rate_ff, rate_in;
   logic [FRAC_W-1:0] frac_ff, frac_in;
   logic              done_ff, done_in;

   logic [31:0]       mul_a;
   logic [19:0]       mul_b;
   logic [51:0]       part;
   logic [DEN_W-1:0]  part_sh;
   logic [53:0]       num_prod;
   logic [NUM_W-1:0]  num_sh;

   always_comb begin
      mul_a    = step_ff[1] ? {1'b0, span_ff[62:32]} : span_ff[31:0];
      mul_b    = step_ff[0] ? rate_ff[39:20] : rate_ff[19:0];
      part     = 52'(mul_a * mul_b);
      case (step_ff[1:0])
         2'd0:    part_sh = DEN_W'(part);
         2'd1:    part_sh = DEN_W'(part) << 20;
         2'd2:    part_sh = DEN_W'(part) << 32;
         default: part_sh = DEN_W'(part) << 52;
      endcase
      num_prod = 54'(calc_req.sum * NS_PER_S);
      num_sh   = num_ff << 1;

      state_in = state_ff;
      step_in  = step_ff;
      num_in   = num_ff;
      den_in   = den_ff;
      span_in  = span_ff;
      rate_in  = rate_ff;
      frac_in  = frac_ff;
      done_in  = 1'b0;
      case (state_ff)
         C_IDLE: begin
            if (calc_req.start) begin
               num_in   = NUM_W'({num_prod, 3'b000});
               den_in   = '0;
               span_in  = calc_req.span;
               rate_in  = calc_req.rate;
               step_in  = '0;
               state_in = C_MUL;
            end
         end
         C_MUL: begin
            den_in  = den_ff + part_sh;
            step_in = step_ff + 4'd1;
            if (step_ff[1:0] == 2'd3) begin
               state_in = C_CMP;
            end
         end
         C_CMP: begin
            // saturate: rate at or above line rate, or zero line rate
            if (num_ff >= NUM_W'(den_ff)) begin
               frac_in  = ONE_FIX;
               done_in  = 1'b1;
               state_in = C_IDLE;
            end else begin
               frac_in  = '0;
               step_in  = '0;
               state_in = C_DIV;
            end
         end
         default: begin
            if (num_sh >= NUM_W'(den_ff)) begin
               num_in  = num_sh - NUM_W'(den_ff);
               frac_in = {frac_ff[FRAC_W-2:0], 1'b1};
            end else begin
               num_in  = num_sh;
               frac_in = {frac_ff[FRAC_W-2:0], 1'b0};
            end
            step_in = step_ff + 4'd1;
            if (step_ff == 4'd15) begin
               done_in  = 1'b1;
               state_in = C_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= C_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      step_ff <= step_in;
      num_ff  <= num_in;
      den_ff  <= den_in;
      span_ff <= span_in;
      rate_ff <= rate_in;
      frac_ff <= frac_in;
   end

   assign calc_rsp.done = done_ff;
   assign calc_rsp.frac = frac_ff;
endmodule

// ===== hdl/windowed_dequeue_rate_estimator_unit.sv =====
// ----------------------------------------------------------------------------
// windowed_dequeue_rate_estimator_unit
// Per-queue sliding-window dequeue rate estimator over a history memory.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake          | beat
//  req_if   | in  | valid/ready        | req_type, port_index, prio_index, byte_count, now_time
//  rsp_if   | out | valid/ready        | rate_fraction, sample_count (queries only)
//  csr_*    | in  | csr_we             | line_rate_bps
//
// One item at a time: a record reads its queue entry, reads the oldest sample when
// the ring is full and writes back when the index is valid; a query reads its queue
// entry and, with more than one sample, two time-stamps, then, if the span is forward,
// runs the multiply, compare and 16-step divide in wdre_calc, which may saturate.
// After reset a clearing pass writes every one of the NUM_PORTS*NUM_PRIOS queue
// entries, during which req_if.ready stays low.
// A response waits in the output register; a further query stalls only when
// its response is ready and the previous one has not been taken.
module windowed_dequeue_rate_estimator_unit #(
   parameter int NUM_PORTS     = 128,
   parameter int NUM_PRIOS     = 8,
   parameter int HISTORY_LIMIT = 100
) (
   input  logic                         clock,
   input  logic                         reset,
   wdre_req_if.sink                     req_if,
   wdre_rsp_if.source                   rsp_if,
   input  logic                         csr_we,
   input  logic [wdre_pkg::RATE_W-1:0]  csr_wdata
);
   import wdre_pkg::*;

   localparam int CAP = HISTORY_LIMIT + 1;
   localparam int NQ  = NUM_PORTS * NUM_PRIOS;
   localparam int SW  = $clog2(CAP);
   localparam int CW  = $clog2(CAP + 1);
   localparam int QW  = NQ > 1 ? $clog2(NQ) : 1;
   localparam int HW  = NQ * CAP > 1 ? $clog2(NQ * CAP) : 1;
   localparam int EW  = SW + CW + SUM_W;
   localparam int HEW = BYTES_W + TIME_W;

   localparam logic [3:0] S_CLR  = 4'd0;
   localparam logic [3:0] S_IDLE = 4'd1;
   localparam logic [3:0] S_QRD  = 4'd2;
   localparam logic [3:0] S_QDAT = 4'd3;
   localparam logic [3:0] S_DEC  = 4'd4;
   localparam logic [3:0] S_HDAT = 4'd5;
   localparam logic [3:0] S_WR   = 4'd6;
   localparam logic [3:0] S_TOLD = 4'd7;
   localparam logic [3:0] S_TNEW = 4'd8;
   localparam logic [3:0] S_CALC = 4'd9;
   localparam logic [3:0] S_RESP = 4'd10;
   localparam logic [3:0] S_TRD  = 4'd11;

   logic [3:0]         state_ff, state_in;
   logic [QW-1:0]      clr_ff, clr_in;
   logic [RATE_W-1:0]  rate_ff;
   logic               type_ff, valid_ff;
   logic [QW-1:0]      q_ff;
   logic [BYTES_W-1:0] bytes_ff;
   logic [TIME_W-1:0]  stamp_ff;
   logic [HW-1:0]      base_ff, base_in;
   logic [SW-1:0]      head_ff, head_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [SUM_W-1:0]   sum_ff, sum_in;
   logic [TIME_W-1:0]  told_ff, told_in;
   logic [FRAC_W-1:0]  res_frac_ff, res_frac_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [FRAC_W-1:0]  rsp_frac_ff, rsp_frac_in;
   logic [CNT_W-1:0]   rsp_cnt_ff, rsp_cnt_in;

   logic               accept;
   logic               q_we, q_re;
   logic [QW-1:0]      q_waddr;
   logic [EW-1:0]      q_wdata, q_rdata;
   logic               h_we, h_re;
   logic [HW-1:0]      h_waddr, h_raddr;
   logic [HEW-1:0]     h_wdata, h_rdata;
   logic [SW:0]        newest_raw, slot_raw;
   logic [SW-1:0]      newest_slot, write_slot, head_next;
   logic [TIME_W-1:0]  h_time;
   logic [BYTES_W-1:0] h_bytes;
   calc_req_type       calc_req;
   calc_rsp_type       calc_rsp;

   assign accept  = req_if.valid && req_if.ready;
   assign h_bytes = h_rdata[HEW-1:TIME_W];
   assign h_time  = h_rdata[TIME_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         rate_ff <= LINE_RATE_RESET;
      end else if (csr_we) begin
         rate_ff <= csr_wdata;
      end
   end

   // hold the accepted beat
   always_ff @(posedge clock) begin
      if (accept) begin
         type_ff  <= req_if.req_type;
         valid_ff <= (int'(req_if.port_index) < NUM_PORTS) &&
                     (int'(req_if.prio_index) < NUM_PRIOS);
         q_ff     <= QW'(int'(req_if.port_index) * NUM_PRIOS + int'(req_if.prio_index));
         bytes_ff <= req_if.byte_count;
         stamp_ff <= req_if.now_time;
      end
   end

   always_comb begin
      newest_raw  = (SW+1)'(head_ff) + (SW+1)'(count_ff) - (SW+1)'(1);
      newest_slot = newest_raw >= (SW+1)'(CAP) ? SW'(newest_raw - (SW+1)'(CAP))
                                                : SW'(newest_raw);
      slot_raw    = (SW+1)'(head_ff) + (SW+1)'(count_ff);
      write_slot  = slot_raw >= (SW+1)'(CAP) ? SW'(slot_raw - (SW+1)'(CAP)) : SW'(slot_raw);
      head_next   = head_ff == SW'(CAP - 1) ? '0 : head_ff + SW'(1);
   end

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      base_in      = base_ff;
      head_in      = head_ff;
      count_in     = count_ff;
      sum_in       = sum_ff;
      told_in      = told_ff;
      res_frac_in  = res_frac_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      rsp_frac_in  = rsp_frac_ff;
      rsp_cnt_in   = rsp_cnt_ff;

      q_we    = 1'b0;
      q_waddr = q_ff;
      q_wdata = {head_ff, count_ff, sum_ff};
      q_re    = 1'b0;
      h_we    = 1'b0;
      h_waddr = base_ff + HW'(write_slot);
      h_wdata = {bytes_ff, stamp_ff};
      h_re    = 1'b0;
      h_raddr = base_ff + HW'(head_ff);

      calc_req.start = 1'b0;
      calc_req.sum   = sum_ff;
      calc_req.span  = h_time - told_ff;
      calc_req.rate  = rate_ff;

      case (state_ff)
         S_CLR: begin
            q_we    = 1'b1;
            q_waddr = clr_ff;
            q_wdata = {SW'(0), CW'(0), SUM_BIAS};
            clr_in  = clr_ff + QW'(1);
            if (clr_ff == QW'(NQ - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               state_in = S_QRD;
            end
         end
         S_QRD: begin
            q_re     = 1'b1;
            base_in  = HW'(int'(q_ff) * CAP);
            state_in = S_QDAT;
         end
         S_QDAT: begin
            head_in  = q_rdata[EW-1:CW+SUM_W];
            count_in = q_rdata[CW+SUM_W-1:SUM_W];
            sum_in   = q_rdata[SUM_W-1:0];
            state_in = S_DEC;
         end
         S_DEC: begin
            if (type_ff == REQ_RECORD) begin
               if (!valid_ff) begin
                  state_in = S_IDLE;
               end else if (count_ff == CW'(CAP)) begin
                  // ring full: fetch the oldest sample to drop it
                  h_re     = 1'b1;
                  state_in = S_HDAT;
               end else begin
                  state_in = S_WR;
               end
            end else if (!valid_ff) begin
               res_frac_in = ONE_FIX;
               count_in    = '0;
               state_in    = S_RESP;
            end else if (count_ff <= CW'(1)) begin
               res_frac_in = ONE_FIX;
               state_in    = S_RESP;
            end else begin
               h_re     = 1'b1;
               state_in = S_TRD;
            end
         end
         S_HDAT: begin
            sum_in   = sum_ff - SUM_W'(h_bytes);
            head_in  = head_next;
            count_in = count_ff - CW'(1);
            state_in = S_WR;
         end
         S_WR: begin
            h_we     = 1'b1;
            q_we     = 1'b1;
            q_wdata  = {head_ff, count_ff + CW'(1), sum_ff + SUM_W'(bytes_ff)};
            state_in = S_IDLE;
         end
         S_TRD: begin
            // oldest stamp is on the read port now; fetch the newest
            told_in  = h_time;
            h_re     = 1'b1;
            h_raddr  = base_ff + HW'(newest_slot);
            state_in = S_TOLD;
         end
         S_TOLD: begin
            state_in = S_TNEW;
         end
         S_TNEW: begin
            if (h_time <= told_ff) begin
               res_frac_in = ONE_FIX;
               state_in    = S_RESP;
            end else begin
               calc_req.start = 1'b1;
               state_in       = S_CALC;
            end
         end
         S_CALC: begin
            if (calc_rsp.done) begin
               res_frac_in = calc_rsp.frac;
               state_in    = S_RESP;
            end
         end
         S_RESP: begin
            if (!rsp_valid_ff || rsp_if.ready) begin
               rsp_valid_in = 1'b1;
               rsp_frac_in  = res_frac_ff;
               rsp_cnt_in   = CNT_W'(count_ff);
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      base_ff     <= base_in;
      head_ff     <= head_in;
      count_ff    <= count_in;
      sum_ff      <= sum_in;
      told_ff     <= told_in;
      res_frac_ff <= res_frac_in;
      rsp_frac_ff <= rsp_frac_in;
      rsp_cnt_ff  <= rsp_cnt_in;
   end

   assign req_if.ready         = state_ff == S_IDLE;
   assign rsp_if.valid         = rsp_valid_ff;
   assign rsp_if.rate_fraction = rsp_frac_ff;
   assign rsp_if.sample_count  = rsp_cnt_ff;

   wdre_ram #(.WIDTH(EW), .DEPTH(NQ)) u_queue_ram (
      .clock   (clock),
      .wr_en   (q_we),
      .wr_addr (q_waddr),
      .wr_data (q_wdata),
      .rd_en   (q_re),
      .rd_addr (q_ff),
      .rd_data (q_rdata)
   );

   wdre_ram #(.WIDTH(HEW), .DEPTH(NQ * CAP)) u_hist_ram (
      .clock   (clock),
      .wr_en   (h_we),
      .wr_addr (h_waddr),
      .wr_data (h_wdata),
      .rd_en   (h_re),
      .rd_addr (h_raddr),
      .rd_data (h_rdata)
   );

   wdre_calc u_calc (
      .clock    (clock),
      .reset    (reset),
      .calc_req (calc_req),
      .calc_rsp (calc_rsp)
   );
endmodule
